// ===== sv/ecat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecat_pkg
// Shared constants and types for the cellular automaton tone block.
// ----------------------------------------------------------------------------
package ecat_pkg;

	localparam int CELLS_DEFAULT = 256;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int RULE_W   = 8;
	localparam int WIDTH_W  = 9;
	localparam int PERIOD_W = 16;
	localparam int SEED_W   = 8;
	localparam int VALUE_W  = 16;

	// fraction bits of the Q1.15 output
	localparam int Q_BITS = 15;

	localparam logic [RULE_W-1:0]   RULE_RESET   = 8'd30;
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd256;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1;
	localparam logic [SEED_W-1:0]   SEED_RESET   = 8'h01;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_RULE   = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_PERIOD = 2'd2,
		CFG_SEED   = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		WALK_FILL = 1'b0,
		WALK_GEN  = 1'b1
	} walk_op_t;

	typedef struct packed {
		logic     go;
		walk_op_t op;
	} walk_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} walk_sts_t;

endpackage

// ===== sv/elementary_cellular_automaton_tone.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementary_cellular_automaton_tone
// Ring of one-bit cells under an elementary rule, sampled as an audio tone.
// ----------------------------------------------------------------------------
// Each tick request advances a 16-bit tick counter; once every step_period
// ticks it runs one generation of the ring and refreshes the held sample
// from the cells as they were before that generation. The cells live in a
// one-bit RAM with a registered read port and are walked one cell a cycle,
// so the cell RAM sets the cost: a generation adds a walk over the n cells
// in use and the 15-bit serial divide, and a reseed adds a fill of the n
// cells, where n is the width in use (width clamped to CELLS). After reset
// the block writes the seed pattern 0x01 across all CELLS entries, one per
// cycle, and stalls tick requests until that pass is done; configuration
// writes are taken at any time but are meant to be issued while no tick is
// in flight. A finished sample may wait in the output register while the
// next tick request is already accepted.
// ----------------------------------------------------------------------------
module elementary_cellular_automaton_tone #(
	parameter int CELLS = ecat_pkg::CELLS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ecat_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ecat_pkg::CFG_DATA_W-1:0]  cfg_data,
	// tick request channel
	input  logic                             tick_valid,
	output logic                             tick_stall,
	input  logic                             reseed,
	// sample channel
	output logic                             sample_valid,
	input  logic                             sample_stall,
	output logic signed [ecat_pkg::VALUE_W-1:0] value,
	output logic                             stepped
);
	import ecat_pkg::*;

	localparam int NW = $clog2(CELLS + 1);
	localparam int SW = $clog2(CELLS * (CELLS - 1) / 2 + 2);

	typedef enum logic [2:0] {
		T_IDLE, T_FILL, T_GEN, T_DIV, T_OUT
	} top_state_t;

	// configuration registers
	logic [RULE_W-1:0]   rule_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [PERIOD_W-1:0] period_q;
	logic [SEED_W-1:0]   seed_q;

	top_state_t                 state_q;
	logic [PERIOD_W-1:0]        tick_q;
	logic                       step_q;
	logic signed [VALUE_W-1:0]  held_q;
	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  out_value_q;
	logic                       out_stepped_q;
	walk_cmd_t                  walk_cmd_q;
	logic                       div_start_q;

	walk_sts_t          walk_sts;
	logic [SW-1:0]      sum_s, sum_d;
	logic               old0;
	logic               div_done;
	logic [Q_BITS-1:0]  quo;

	logic [NW-1:0]       n_used;
	logic [PERIOD_W-1:0] period_eff;
	logic                take_tick, step_now, out_free;
	logic [VALUE_W-1:0]  mag;

	// ------------------------------------------------------------------
	// configuration: always ready, written by index
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q   <= RULE_RESET;
			width_q  <= WIDTH_RESET;
			period_q <= PERIOD_RESET;
			seed_q   <= SEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_RULE:   rule_q   <= cfg_data[RULE_W-1:0];
				CFG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				CFG_SEED:   seed_q   <= cfg_data[SEED_W-1:0];
				default:    ;
			endcase
		end
	end

	// clamp width to the ring; a zero period counts as one
	assign n_used     = (32'(width_q) > CELLS) ? NW'(CELLS) : NW'(width_q);
	assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

	// ------------------------------------------------------------------
	// tick handshake: take a request only when both sequencers are idle
	// ------------------------------------------------------------------
	assign tick_stall = !((state_q == T_IDLE) && walk_sts.idle);
	assign take_tick  = tick_valid && !tick_stall;
	assign step_now   = tick_q >= period_eff;
	assign out_free   = !out_valid_q || !sample_stall;

	// sign-magnitude to two's complement; magnitude never exceeds 32767
	assign mag = {1'b0, quo};

	ecat_walk #(.CELLS(CELLS), .NW(NW), .SW(SW)) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (walk_cmd_q),
		.n      (n_used),
		.rule   (rule_q),
		.seed   (seed_q),
		.sts    (walk_sts),
		.sum_s  (sum_s),
		.sum_d  (sum_d),
		.old0   (old0)
	);

	ecat_div #(.SW(SW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (sum_s),
		.den    (sum_d),
		.done   (div_done),
		.quo    (quo)
	);

	// ------------------------------------------------------------------
	// tick sequencer and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= T_IDLE;
			tick_q        <= '0;
			step_q        <= 1'b0;
			held_q        <= '0;
			out_valid_q   <= 1'b0;
			out_value_q   <= '0;
			out_stepped_q <= 1'b0;
			walk_cmd_q    <= '{go: 1'b0, op: WALK_FILL};
			div_start_q   <= 1'b0;
		end else begin
			// drop one-cycle pulses by default
			walk_cmd_q.go <= 1'b0;
			div_start_q   <= 1'b0;
			if (out_valid_q && !sample_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				T_IDLE: begin
					if (take_tick) begin
						// advance the counter now; the walk follows
						tick_q <= (step_now ? tick_q - period_eff : tick_q)
							+ PERIOD_W'(1);
						step_q <= step_now;
						if (reseed) begin
							walk_cmd_q <= '{go: 1'b1, op: WALK_FILL};
							state_q    <= T_FILL;
						end else if (step_now) begin
							walk_cmd_q <= '{go: 1'b1, op: WALK_GEN};
							state_q    <= T_GEN;
						end else begin
							state_q <= T_OUT;
						end
					end
				end
				T_FILL: begin
					if (walk_sts.done) begin
						if (step_q) begin
							walk_cmd_q <= '{go: 1'b1, op: WALK_GEN};
							state_q    <= T_GEN;
						end else begin
							state_q <= T_OUT;
						end
					end
				end
				T_GEN: begin
					if (walk_sts.done) begin
						div_start_q <= 1'b1;
						state_q     <= T_DIV;
					end
				end
				T_DIV: begin
					if (div_done) begin
						held_q  <= old0 ? -$signed(mag) : $signed(mag);
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					// hold the sample until the output register frees up
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_value_q   <= held_q;
						out_stepped_q <= step_q;
						state_q       <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign sample_valid = out_valid_q;
	assign value        = out_value_q;
	assign stepped      = out_stepped_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// an accepted tick request keeps the channel stalled while it is worked on
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take_tick |=> tick_stall)
		else $error("tick request taken while previous one still in work");

	// a new sample is only loaded from the output stage of the sequencer
	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid) |-> $past(state_q == T_OUT))
		else $error("sample presented outside the output stage");

	// the cell walk and a tick request never run side by side
	a_walk_blocks_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!walk_sts.idle |-> tick_stall)
		else $error("tick request open while cell walk is busy");

	// a generation result arrives only while waiting on the divider
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == T_DIV))
		else $error("divider finished outside the divide stage");

endmodule

// ===== sv/ecat_cell_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecat_cell_ram
// One-bit cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ecat_cell_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/ecat_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecat_walk
// Serial walk over the cell store: reset pass, seed fill and one generation
// with the index sums of the old cells.
// ----------------------------------------------------------------------------
module ecat_walk #(
	parameter int CELLS = 256,
	parameter int NW    = 9,
	parameter int SW    = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ecat_pkg::walk_cmd_t           cmd,
	input  logic [NW-1:0]                 n,
	input  logic [ecat_pkg::RULE_W-1:0]   rule,
	input  logic [ecat_pkg::SEED_W-1:0]   seed,
	output ecat_pkg::walk_sts_t           sts,
	output logic [SW-1:0]                 sum_s,
	output logic [SW-1:0]                 sum_d,
	output logic                          old0
);
	import ecat_pkg::*;

	localparam int AW = $clog2(CELLS);
	localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

	typedef enum logic [2:0] {
		W_INIT, W_IDLE, W_FILL, W_GA, W_GB, W_GC, W_RUN
	} walk_state_t;

	walk_state_t   state_q;
	logic [AW-1:0] i_q;
	logic          left_q, cur_q, old0_q, done_q;
	logic [SW-1:0] s_q, d_q;

	logic          we, wdata, rdata, right_bit, new_bit, last_n;
	logic [AW-1:0] raddr;

	ecat_cell_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (i_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// right neighbor of the top cell wraps to cell 0, already overwritten
	assign right_bit = (i_q == LAST) ? old0_q : rdata;
	assign new_bit   = rule[{left_q, cur_q, right_bit}];
	assign last_n    = (NW'(i_q) + NW'(1)) == n;

	always_comb begin
		we    = 1'b0;
		wdata = 1'b0;
		raddr = i_q + AW'(2);
		unique case (state_q)
			W_INIT: begin
				we    = 1'b1;
				wdata = SEED_RESET[i_q[2:0]];
			end
			W_FILL: begin
				we    = 1'b1;
				wdata = seed[i_q[2:0]];
			end
			W_GA: raddr = LAST;
			W_GB: raddr = '0;
			W_GC: raddr = AW'(1);
			W_RUN: begin
				we    = 1'b1;
				wdata = new_bit;
			end
			W_IDLE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_INIT;
			i_q     <= '0;
			done_q  <= 1'b0;
			old0_q  <= 1'b0;
			left_q  <= 1'b0;
			cur_q   <= 1'b0;
			s_q     <= '0;
			d_q     <= SW'(1);
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				W_INIT: begin
					i_q <= i_q + AW'(1);
					if (i_q == LAST) begin
						i_q     <= '0;
						state_q <= W_IDLE;
					end
				end
				W_IDLE: begin
					if (cmd.go) begin
						i_q <= '0;
						if (n == '0) begin
							done_q <= 1'b1;
							s_q    <= '0;
							d_q    <= SW'(1);
							old0_q <= 1'b0;
						end else if (cmd.op == WALK_FILL) begin
							state_q <= W_FILL;
						end else begin
							s_q     <= '0;
							d_q     <= SW'(1);
							state_q <= W_GA;
						end
					end
				end
				W_FILL: begin
					i_q <= i_q + AW'(1);
					if (last_n) begin
						done_q  <= 1'b1;
						state_q <= W_IDLE;
					end
				end
				W_GA: state_q <= W_GB;
				W_GB: begin
					left_q  <= rdata;
					state_q <= W_GC;
				end
				W_GC: begin
					cur_q   <= rdata;
					old0_q  <= rdata;
					i_q     <= '0;
					state_q <= W_RUN;
				end
				W_RUN: begin
					if (cur_q) begin
						s_q <= s_q + SW'(i_q);
					end
					d_q    <= d_q + SW'(i_q);
					left_q <= cur_q;
					cur_q  <= right_bit;
					i_q    <= i_q + AW'(1);
					if (last_n) begin
						done_q  <= 1'b1;
						state_q <= W_IDLE;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	assign sts.idle = (state_q == W_IDLE);
	assign sts.done = done_q;
	assign sum_s    = s_q;
	assign sum_d    = d_q;
	assign old0     = old0_q;

endmodule

// ===== sv/ecat_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecat_div
// Restoring divider, one quotient bit a cycle: q = floor(num * 2^15 / den),
// with num below den.
// ----------------------------------------------------------------------------
module ecat_div #(
	parameter int SW = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [SW-1:0]               num,
	input  logic [SW-1:0]               den,
	output logic                        done,
	output logic [ecat_pkg::Q_BITS-1:0] quo
);
	import ecat_pkg::*;

	localparam int CW = $clog2(Q_BITS + 1);

	logic [SW-1:0]     rem_q, den_q;
	logic [Q_BITS-1:0] quo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;

	logic [SW:0] twice;
	logic        fits;

	assign twice = {rem_q, 1'b0};
	assign fits  = twice >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(Q_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? SW'(twice - {1'b0, den_q}) : SW'(twice);
			quo_q <= {quo_q[Q_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== sim/tb_elementary_cellular_automaton_tone.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elementary_cellular_automaton_tone
// Self-checking bench for the cellular automaton tone block.
// ----------------------------------------------------------------------------
// Tick requests come from a pending queue that the stimulus process fills one
// phase at a time. Every accepted request is run through a local model of the
// ring, the tick counter and the held sample, and the predicted sample joins a
// FIFO. Each sample that leaves the block is checked against the oldest one.
// Registers change only between phases, once every sample has come back.
// ----------------------------------------------------------------------------
module tb_elementary_cellular_automaton_tone;

	import ecat_pkg::*;

	localparam int CELLS       = CELLS_DEFAULT;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int TAIL_CYCLES = 600;
	localparam int RAND_PHASES = 30;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      stepped;
	} tone_sample_t;

	// block ports; every input starts at a known value
	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_W-1:0]    cfg_index    = CFG_RULE;
	logic [CFG_DATA_W-1:0]     cfg_data     = '0;
	logic                      tick_valid   = 1'b0;
	logic                      tick_stall;
	logic                      reseed       = 1'b0;
	logic                      sample_valid;
	logic                      sample_stall = 1'b0;
	logic signed [VALUE_W-1:0] value;
	logic                      stepped;

	// local copy of the registers and of the block state
	logic [RULE_W-1:0]         m_rule;
	logic [WIDTH_W-1:0]        m_width;
	logic [PERIOD_W-1:0]       m_period;
	logic [SEED_W-1:0]         m_seed;
	logic [CELLS-1:0]          ring;
	logic [15:0]               ticks;
	logic signed [VALUE_W-1:0] held;

	bit           pending_ticks[$];
	tone_sample_t due_samples[$];

	int  fail_count   = 0;
	int  sample_count = 0;
	int  cycle_count  = 0;
	bit  tick_took    = 1'b0;
	bit  sender_steady = 1'b0;
	int  burst_left   = 1;
	int  gap_left     = 0;
	logic [31:0] stall_pat = '0;
	int  stall_pos    = 0;

	elementary_cellular_automaton_tone #(
		.CELLS(CELLS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.reseed      (reseed),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.value       (value),
		.stepped     (stepped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Print one line per mismatch and count it; cap the printing so a broken
	// block cannot flood the log.
	task automatic report_mismatch(input string msg);
		if (fail_count < 100)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		fail_count++;
	endtask

	// Advance the local model by one tick and return the sample it yields.
	function automatic tone_sample_t tone_tick(input bit refill);
		tone_sample_t     s;
		logic [CELLS-1:0] old_ring;
		int               n;
		int               period;
		int               lft;
		int               rgt;
		int               mag;
		longint           sum_set;
		longint           sum_all;
		longint           q;
		logic [2:0]       hood;

		n      = (m_width > CELLS) ? CELLS : int'(m_width);
		period = (m_period == 0) ? 1 : int'(m_period);
		s.stepped = 1'b0;

		// reseed: repeat the 8-bit pattern over the cells in use
		if (refill)
			for (int i = 0; i < n; i++)
				ring[i] = m_seed[i % 8];

		if (int'(ticks) >= period) begin
			ticks    = ticks - period[15:0];
			old_ring = ring;
			sum_set  = 0;
			sum_all  = 1;
			for (int i = 0; i < n; i++) begin
				lft  = (i == 0) ? CELLS - 1 : i - 1;
				rgt  = (i + 1 >= CELLS) ? 0 : i + 1;
				hood = {old_ring[lft], old_ring[i], old_ring[rgt]};
				ring[i] = m_rule[hood];
				sum_all += i;
				if (old_ring[i])
					sum_set += i;
			end
			// the sample comes from the cells as they were before the update
			q = (sum_set * 32768) / sum_all;
			if (q > 32767)
				q = 32767;
			mag  = int'(q);
			held = old_ring[0] ? -mag[15:0] : mag[15:0];
			s.stepped = 1'b1;
		end
		ticks   = ticks + 16'd1;
		s.value = held;
		return s;
	endfunction

	// Check samples and predict ticks on the rising edge; end the run if the
	// cycle budget runs out.
	always @(posedge clk) begin
		tone_sample_t got;
		tone_sample_t want;

		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TB_ERROR");
			$finish;
		end else begin
			tick_took = 1'b0;
			if (arst_n) begin
				// check the outgoing sample before predicting the next one
				if (sample_valid && !sample_stall) begin
					got.value   = value;
					got.stepped = stepped;
					if (due_samples.size() == 0) begin
						report_mismatch($sformatf("unexpected sample value %0d stepped %0b",
							got.value, got.stepped));
					end else begin
						want = due_samples.pop_front();
						if (got.value !== want.value)
							report_mismatch($sformatf("sample %0d value %0d, want %0d",
								sample_count, got.value, want.value));
						if (got.stepped !== want.stepped)
							report_mismatch($sformatf("sample %0d stepped %0b, want %0b",
								sample_count, got.stepped, want.stepped));
					end
					sample_count++;
				end
				if (tick_valid && !tick_stall) begin
					tick_took = 1'b1;
					due_samples.push_back(tone_tick(reseed));
				end
			end
		end
	end

	// Tick request driver: bursts of back-to-back requests with random gaps.
	// Hold the payload while the block stalls; advance only after a take.
	always @(negedge clk) begin
		if (arst_n && (!tick_valid || tick_took)) begin
			if (gap_left != 0 || pending_ticks.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				tick_valid <= 1'b0;
			end else begin
				reseed     <= pending_ticks.pop_front();
				tick_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 20);
					if (sender_steady || $urandom_range(0, 3) == 0)
						gap_left = 0;
					else
						gap_left = $urandom_range(1, 12);
				end
			end
		end
	end

	// Sample stall pattern: a 32-bit word stepped through bit by bit, reloaded after its last bit.
	// Zero words give stretches with no back-pressure at all.
	always @(negedge clk) begin
		if (stall_pos == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = '0;
				1: stall_pat = $urandom & $urandom;
				default: stall_pat = $urandom;
			endcase
		end
		sample_stall <= stall_pat[stall_pos];
		stall_pos = (stall_pos + 1) % 32;
	end

	// Wait until no request is queued or in flight and every sample is back.
	task automatic settle();
		do
			@(posedge clk);
		while (pending_ticks.size() != 0 || tick_valid || due_samples.size() != 0);
	endtask

	// Write one register over the configuration channel and mirror it.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_RULE:   m_rule   = data[RULE_W-1:0];
			CFG_WIDTH:  m_width  = data[WIDTH_W-1:0];
			CFG_PERIOD: m_period = data[PERIOD_W-1:0];
			CFG_SEED:   m_seed   = data[SEED_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_ticks(input int count, input int reseed_odds);
		for (int k = 0; k < count; k++)
			pending_ticks.push_back($urandom_range(0, reseed_odds - 1) == 0);
	endtask

	initial begin
		logic [15:0] junk;
		logic [8:0]  wval;
		logic [15:0] pval;
		logic [7:0]  bval;

		// model state at reset: seed 0x01 repeated over the whole ring
		m_rule   = RULE_RESET;
		m_width  = WIDTH_RESET;
		m_period = PERIOD_RESET;
		m_seed   = SEED_RESET;
		for (int i = 0; i < CELLS; i++)
			ring[i] = (i % 8 == 0);
		ticks = '0;
		held  = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// reset registers: full width, period one, reseed with the reset seed
		pending_ticks = '{1'b0, 1'b0, 1'b1, 1'b0};
		settle();

		// all-ones rule, width beyond the ring, period zero acting as one
		write_reg(CFG_RULE,   16'hFFFF);
		write_reg(CFG_WIDTH,  16'd511);
		write_reg(CFG_PERIOD, 16'd0);
		write_reg(CFG_SEED,   16'hFFAA);
		pending_ticks = '{1'b1, 1'b0, 1'b0};
		settle();

		// width zero: nothing evolves, sample stays at zero
		write_reg(CFG_WIDTH, 16'hFE00);
		write_reg(CFG_RULE,  16'h0096);
		pending_ticks = '{1'b0, 1'b1};
		settle();

		// seed zero clears the cells; single-cell ring segment, rule zero
		write_reg(CFG_SEED,   16'h0000);
		write_reg(CFG_WIDTH,  16'd1);
		write_reg(CFG_RULE,   16'h0000);
		write_reg(CFG_PERIOD, 16'd2);
		pending_ticks = '{1'b1, 1'b0, 1'b0, 1'b0};
		settle();

		// longest period: the counter climbs with no generation
		write_reg(CFG_PERIOD, 16'hFFFF);
		write_reg(CFG_WIDTH,  16'd16);
		write_reg(CFG_SEED,   16'h005A);
		write_reg(CFG_RULE,   16'd110);
		pending_ticks = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
		settle();

		// stale counter: a short period drains it one generation per tick
		write_reg(CFG_PERIOD, 16'd2);
		pending_ticks = '{1'b0, 1'b0, 1'b0, 1'b0};
		settle();

		// --- random phases: mostly narrow rings, a few wide ones ---
		repeat (RAND_PHASES) begin
			bit wrote;

			wrote = 1'b0;
			junk  = 16'($urandom);
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 7))
					0: bval = 8'h00;
					1: bval = 8'hFF;
					default: bval = 8'($urandom);
				endcase
				write_reg(CFG_RULE, {junk[15:8], bval});
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 15))
					0: wval = 9'd0;
					1: wval = 9'd256;
					2: wval = 9'($urandom_range(257, 511));
					3: wval = 9'($urandom_range(41, 255));
					default: wval = 9'($urandom_range(1, 40));
				endcase
				write_reg(CFG_WIDTH, {junk[6:0], wval});
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0: pval = 16'd0;
					1: pval = 16'hFFFF;
					2: pval = 16'($urandom_range(5, 300));
					default: pval = 16'($urandom_range(1, 4));
				endcase
				write_reg(CFG_PERIOD, pval);
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1) == 0 || !wrote) begin
				case ($urandom_range(0, 7))
					0: bval = 8'h00;
					1: bval = 8'hFF;
					default: bval = 8'($urandom);
				endcase
				write_reg(CFG_SEED, {junk[7:0], bval});
			end

			// some phases run the sender flat out
			sender_steady = ($urandom_range(0, 3) == 0);
			queue_ticks($urandom_range(20, 40), 8);
			// pause the sender until every sample is back
			settle();
		end

		// drain: let any stray sample show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && due_samples.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
